### src/vscr_pkg.sv
// Shared types and constants for the variable size clock replacement unit.
`timescale 1ns / 1ps

package vscr_pkg;

  // Fixed field widths of the item and result words
  localparam int SLOT_W     = 5;
  localparam int COUNT_W    = 3;
  localparam int KEY_IN_W   = 16;
  localparam int START_W    = 5;
  localparam int EVICT_W    = 6;
  localparam int START_VAL_W = 2;

  // Reset value of the start-value register
  localparam logic [START_VAL_W-1:0] START_VAL_RESET = 2'd1;

  // Operation codes
  localparam logic OP_PROMOTE  = 1'b0;
  localparam logic OP_ALLOCATE = 1'b1;

  // Sequencer states
  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_PROMOTE = 8'b0000_0010,
    ST_SCAN    = 8'b0000_0100,
    ST_ALIGN   = 8'b0000_1000,
    ST_SKIP    = 8'b0001_0000,
    ST_SWEEP   = 8'b0010_0000,
    ST_FILL    = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } vscr_state_t;

  // Write strobes into the slot store
  typedef struct packed {
    logic cnt_we;
    logic key_we;
    logic valid_we;
    logic valid_val;
  } vscr_wr_ctl_t;

endpackage

### src/vscr_slot_store.sv
// Slot store: valid flags, counters and keys, one write and one registered read per cycle.
`timescale 1ns / 1ps

module vscr_slot_store import vscr_pkg::*; #(
  parameter int SLOTS        = 32,
  parameter int COUNTER_BITS = 2,
  parameter int KEY_BITS     = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [$clog2(SLOTS)-1:0]   rd_idx,
  input  logic [$clog2(SLOTS)-1:0]   wr_idx,
  input  vscr_wr_ctl_t               wr,
  input  logic [COUNTER_BITS-1:0]    wr_cnt,
  input  logic [KEY_BITS-1:0]        wr_key,
  output logic                       rd_valid,
  output logic [COUNTER_BITS-1:0]    rd_cnt,
  output logic [KEY_BITS-1:0]        rd_key
);

  logic [KEY_BITS-1:0]     key_mem [SLOTS];
  logic [COUNTER_BITS-1:0] cnt_mem [SLOTS];
  logic [SLOTS-1:0]        valid_q;
  logic [SLOTS-1:0]        seen_q;
  logic [COUNTER_BITS-1:0] cnt_rd;
  logic                    seen_rd;

  // Key and counter memories, read data registered
  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr_idx] <= wr_key;
    end
    if (wr.cnt_we) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    rd_key <= key_mem[rd_idx];
    cnt_rd <= cnt_mem[rd_idx];
  end

  // Valid flags and counter-written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      seen_q  <= '0;
    end else begin
      if (wr.valid_we) begin
        valid_q[wr_idx] <= wr.valid_val;
      end
      if (wr.cnt_we) begin
        seen_q[wr_idx] <= 1'b1;
      end
    end
  end

  // Register the flag reads alongside the memory reads
  always_ff @(posedge clk) begin
    rd_valid <= valid_q[rd_idx];
    seen_rd  <= seen_q[rd_idx];
  end

  // A counter never written reads as zero
  assign rd_cnt = seen_rd ? cnt_rd : '0;

endmodule

### src/variable_size_clock_replacement_unit.sv
// Top level of the variable size clock replacement unit: sequencer over the slot store.
// Sequence: promote raises the counters of count slots and then gives its result; allocate
//   first scans for a free run of slots, then if needed runs a clock sweep of one slot a cycle
//   (up to about 2^COUNTER_BITS passes over the bucket), then fills count slots.
// Throughput: one word at a time; the store visits one slot per cycle.
// Reset: valid flags and the hand clear and counters read as zero; keys stay undefined.
`timescale 1ns / 1ps

module variable_size_clock_replacement_unit import vscr_pkg::*; #(
  parameter int SLOTS            = 32,
  parameter int COUNTER_BITS     = 2,
  parameter int MAX_OBJECT_SLOTS = 4,
  parameter int KEY_BITS         = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   counter_start_value_we,
  input  logic [START_VAL_W-1:0] counter_start_value,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   operation,
  input  logic [SLOT_W-1:0]      slot,
  input  logic [COUNT_W-1:0]     count,
  input  logic [KEY_IN_W-1:0]    key,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [START_W-1:0]     start_slot,
  output logic [EVICT_W-1:0]     evicted_slots
);

  localparam int IW      = $clog2(SLOTS);
  localparam int CW      = $clog2(SLOTS + 1);
  localparam int NW      = $clog2(MAX_OBJECT_SLOTS + 1);
  localparam int CNT_MAX = (1 << COUNTER_BITS) - 1;
  localparam int N_LIMIT = (MAX_OBJECT_SLOTS < SLOTS) ? MAX_OBJECT_SLOTS : SLOTS;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  vscr_state_t state, state_next;
  logic [CW-1:0]           cur, cur_next;
  logic [CW-1:0]           hand, hand_next;
  logic [CW-1:0]           start, start_next;
  logic [NW-1:0]           n, n_next;
  logic [NW-1:0]           step, step_next;
  logic [NW-1:0]           avail, avail_next;
  logic [NW-1:0]           avail_inc;
  logic [NW-1:0]           n_in;
  logic                    in_walk, in_walk_next;
  logic [KEY_BITS-1:0]     k, k_next;
  logic [KEY_BITS-1:0]     new_key, new_key_next;
  logic [EVICT_W-1:0]      ev, ev_next;
  logic [START_VAL_W-1:0]  start_value;
  logic [COUNTER_BITS-1:0] init_cnt;
  logic                    at_limit;
  logic                    cur_in;

  vscr_wr_ctl_t            wr;
  logic [COUNTER_BITS-1:0] wr_cnt;
  logic [IW-1:0]           rd_idx;
  logic                    rd_valid;
  logic [COUNTER_BITS-1:0] rd_cnt;
  logic [KEY_BITS-1:0]     rd_key;

  // Start-value register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= START_VAL_RESET;
    end else if (counter_start_value_we) begin
      start_value <= counter_start_value;
    end
  end

  // Saturate the start value to the counter range
  always_comb begin
    if (int'(start_value) > CNT_MAX) begin
      init_cnt = '1;
    end else begin
      init_cnt = COUNTER_BITS'(start_value);
    end
  end

  // Clamp the requested slot count
  always_comb begin
    if (count == '0) begin
      n_in = NW'(1);
    end else if (int'(count) > N_LIMIT) begin
      n_in = NW'(N_LIMIT);
    end else begin
      n_in = NW'(count);
    end
  end

  assign at_limit  = (avail >= n);
  assign avail_inc = at_limit ? avail : avail + NW'(1);
  assign cur_in    = (cur < SLOTS_C);
  assign in_ready  = (state == ST_IDLE);

  // Sequencer
  always_comb begin
    state_next   = state;
    cur_next     = cur;
    hand_next    = hand;
    start_next   = start;
    n_next       = n;
    step_next    = step;
    avail_next   = avail;
    in_walk_next = in_walk;
    k_next       = k;
    new_key_next = new_key;
    ev_next      = ev;
    wr           = '0;
    wr_cnt       = rd_cnt;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          n_next       = n_in;
          step_next    = '0;
          avail_next   = '0;
          ev_next      = '0;
          start_next   = '0;
          new_key_next = KEY_BITS'(key);
          if (operation == OP_PROMOTE) begin
            // a start beyond the bucket parks the pointer at the end
            cur_next   = (int'(slot) < SLOTS) ? CW'(slot) : SLOTS_C;
            state_next = ST_PROMOTE;
          end else begin
            cur_next   = '0;
            state_next = ST_SCAN;
          end
        end
      end

      ST_PROMOTE: begin
        if (cur_in) begin
          wr.cnt_we = 1'b1;
          wr_cnt    = (rd_cnt != {COUNTER_BITS{1'b1}}) ? rd_cnt + COUNTER_BITS'(1) : rd_cnt;
          cur_next  = cur + CW'(1);
        end
        step_next = step + NW'(1);
        if (step + NW'(1) == n) begin
          state_next = ST_DONE;
        end
      end

      ST_SCAN: begin
        if (at_limit) begin
          start_next = cur - CW'(n);
          cur_next   = cur - CW'(n);
          step_next  = '0;
          state_next = ST_FILL;
        end else if (!cur_in) begin
          // no free run: start the sweep, first aligning the hand to an object head
          avail_next   = '0;
          in_walk_next = 1'b0;
          if (hand != '0 && hand < SLOTS_C) begin
            cur_next   = hand - CW'(1);
            state_next = ST_ALIGN;
          end else begin
            cur_next   = hand;
            state_next = ST_SWEEP;
          end
        end else begin
          avail_next = rd_valid ? '0 : avail_inc;
          cur_next   = cur + CW'(1);
        end
      end

      ST_ALIGN: begin
        // hold the key of the slot before the hand
        k_next       = rd_key;
        in_walk_next = 1'b0;
        cur_next     = cur + CW'(1);
        state_next   = ST_SKIP;
      end

      ST_SKIP: begin
        if (cur_in && rd_key == k && (in_walk || rd_valid)) begin
          in_walk_next = 1'b1;
          cur_next     = cur + CW'(1);
        end else begin
          in_walk_next = 1'b0;
          avail_next   = '0;
          state_next   = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        if (!cur_in) begin
          if (at_limit) begin
            hand_next  = cur;
            start_next = cur - CW'(n);
            cur_next   = cur - CW'(n);
            step_next  = '0;
            state_next = ST_FILL;
          end else begin
            // wrap to the head of the bucket
            cur_next     = '0;
            avail_next   = '0;
            in_walk_next = 1'b0;
          end
        end else if (!(in_walk && rd_key == k) && at_limit) begin
          hand_next  = cur;
          start_next = cur - CW'(n);
          cur_next   = cur - CW'(n);
          step_next  = '0;
          state_next = ST_FILL;
        end else if (!(in_walk && rd_key == k) && !rd_valid) begin
          avail_next   = avail_inc;
          in_walk_next = 1'b0;
          cur_next     = cur + CW'(1);
        end else begin
          // walk the object: drop zero counters, age the rest
          if (!(in_walk && rd_key == k)) begin
            k_next       = rd_key;
            in_walk_next = 1'b1;
          end
          if (rd_cnt == '0) begin
            if (rd_valid) begin
              ev_next = ev + EVICT_W'(1);
            end
            wr.valid_we  = 1'b1;
            wr.valid_val = 1'b0;
            avail_next   = avail_inc;
          end else begin
            wr.cnt_we  = 1'b1;
            wr_cnt     = rd_cnt - COUNTER_BITS'(1);
            avail_next = '0;
          end
          cur_next = cur + CW'(1);
        end
      end

      ST_FILL: begin
        wr.cnt_we    = 1'b1;
        wr.key_we    = 1'b1;
        wr.valid_we  = 1'b1;
        wr.valid_val = 1'b1;
        wr_cnt       = init_cnt;
        cur_next     = cur + CW'(1);
        step_next    = step + NW'(1);
        if (step + NW'(1) == n) begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Read the slot the pointer moves to next
  assign rd_idx = (cur_next < SLOTS_C) ? cur_next[IW-1:0] : '0;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      hand    <= '0;
      in_walk <= 1'b0;
    end else begin
      state   <= state_next;
      hand    <= hand_next;
      in_walk <= in_walk_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cur     <= cur_next;
    start   <= start_next;
    n       <= n_next;
    step    <= step_next;
    avail   <= avail_next;
    k       <= k_next;
    new_key <= new_key_next;
    ev      <= ev_next;
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      start_slot    <= START_W'(start);
      evicted_slots <= ev;
    end
  end

  vscr_slot_store #(
    .SLOTS        (SLOTS),
    .COUNTER_BITS (COUNTER_BITS),
    .KEY_BITS     (KEY_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_idx),
    .wr_idx   (cur[IW-1:0]),
    .wr       (wr),
    .wr_cnt   (wr_cnt),
    .wr_key   (new_key),
    .rd_valid (rd_valid),
    .rd_cnt   (rd_cnt),
    .rd_key   (rd_key)
  );

endmodule
